@@ rtl/u8ve_pkg.sv @@
// shared types, constants and helper functions for the utf-8 validating escaper
package u8ve_pkg;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_X         = 8'h78;
    localparam logic [7:0] ASCII_SPACE    = 8'h20;
    localparam logic [7:0] ASCII_DEL      = 8'h7F;
    localparam logic [7:0] CONT_MASK      = 8'hC0;
    localparam logic [7:0] CONT_TAG       = 8'h80;
    localparam logic [2:0] QUEUE_DEPTH    = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic decide;
        logic emit;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic stop;
        logic final_push;
    } status_t;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b >= 8'hC2 && b <= 8'hDF) len = 3'd2;
        else if (b >= 8'hE0 && b <= 8'hEF) len = 3'd3;
        else if (b >= 8'hF0 && b <= 8'hF4) len = 3'd4;
        return len;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) c = 8'h30 + {4'd0, d};
        else c = 8'h37 + {4'd0, d};
        return c;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_TAG;
    endfunction

    // well-formedness of a complete multi-byte sequence starting at b0
    function automatic logic seq_ok(input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2, input logic [7:0] b3,
                                    input logic [2:0] len);
        logic ok;
        ok = 1'b0;
        case (len)
            3'd2: ok = is_cont(b1);
            3'd3: begin
                ok = is_cont(b1) && is_cont(b2);
                // overlong below u+0800 and surrogate range
                if (b0 == 8'hE0 && b1 < 8'hA0) ok = 1'b0;
                if (b0 == 8'hED && b1 > 8'h9F) ok = 1'b0;
            end
            3'd4: begin
                ok = is_cont(b1) && is_cont(b2) && is_cont(b3);
                // overlong below u+10000 and above u+10ffff
                if (b0 == 8'hF0 && b1 < 8'h90) ok = 1'b0;
                if (b0 == 8'hF4 && b1 > 8'h8F) ok = 1'b0;
            end
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

@@ rtl/u8ve_ctrl.sv @@
// sequencer: accept a byte, judge the head of the queue, emit characters
module u8ve_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  u8ve_pkg::status_t status,
    output u8ve_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.stop) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.decide = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                cmd.emit = 1'b1;
                if (status.final_push) state_next = ST_SCAN;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/u8ve_datapath.sv @@
// byte queue, sequence judgment and output register
module u8ve_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  u8ve_pkg::cmd_t    cmd,
    input  u8ve_pkg::in_t     s_data,
    output u8ve_pkg::status_t status,
    output logic              m_valid,
    input  logic              m_ready,
    output u8ve_pkg::out_t    m_data
);

    logic [7:0] byte0_reg, byte1_reg, byte2_reg, byte3_reg;
    logic [7:0] byte0_next, byte1_next, byte2_next, byte3_next;
    logic [2:0] count_reg, count_next;
    logic       end_reg;
    logic       esc_reg;
    logic [2:0] take_reg;
    logic [1:0] idx_reg, idx_next;
    logic       more_reg;
    logic       out_valid_reg;
    u8ve_pkg::out_t out_reg;

    // head-of-queue judgment
    logic [2:0] head_len;
    logic       hold;
    logic       dec_esc;
    logic [2:0] dec_take;
    logic [2:0] rem;
    logic [7:0] front;
    logic [2:0] front_len;
    logic       dec_more;

    // emission
    logic       slot_free;
    logic       push;
    logic [1:0] final_idx;
    logic       at_final;
    logic [7:0] emit_char;

    always_comb begin
        head_len = u8ve_pkg::lead_length(byte0_reg);
        hold = 1'b0;
        dec_esc = 1'b1;
        dec_take = 3'd1;
        if (byte0_reg < u8ve_pkg::CONT_TAG) begin
            dec_esc = (byte0_reg < u8ve_pkg::ASCII_SPACE) || (byte0_reg == u8ve_pkg::ASCII_DEL);
        end else if (head_len == 3'd0) begin
            dec_esc = 1'b1;
        end else if (head_len > count_reg) begin
            hold = !end_reg;
        end else if (u8ve_pkg::seq_ok(byte0_reg, byte1_reg, byte2_reg, byte3_reg, head_len))
        begin
            dec_esc = 1'b0;
            dec_take = head_len;
        end
    end

    // does anything follow once this transaction's bytes are consumed
    always_comb begin
        rem = count_reg - dec_take;
        case (dec_take)
            3'd1:    front = byte1_reg;
            3'd2:    front = byte2_reg;
            3'd3:    front = byte3_reg;
            default: front = byte0_reg;
        endcase
        front_len = u8ve_pkg::lead_length(front);
        dec_more = (rem != 3'd0) && (end_reg || front_len == 3'd0 || front_len <= rem);
    end

    assign slot_free = !out_valid_reg || m_ready;
    assign push = cmd.emit && slot_free;
    assign final_idx = esc_reg ? 2'd3 : take_reg[1:0] - 2'd1;
    assign at_final = (idx_reg == final_idx);
    assign status = '{stop: (count_reg == 3'd0) || hold, final_push: push && at_final};

    always_comb begin
        if (esc_reg) begin
            case (idx_reg)
                2'd0:    emit_char = u8ve_pkg::CHAR_BACKSLASH;
                2'd1:    emit_char = u8ve_pkg::CHAR_X;
                2'd2:    emit_char = u8ve_pkg::hex_char(byte0_reg[7:4]);
                default: emit_char = u8ve_pkg::hex_char(byte0_reg[3:0]);
            endcase
        end else begin
            case (idx_reg)
                2'd0:    emit_char = byte0_reg;
                2'd1:    emit_char = byte1_reg;
                2'd2:    emit_char = byte2_reg;
                default: emit_char = byte3_reg;
            endcase
        end
    end

    always_comb begin
        byte0_next = byte0_reg;
        byte1_next = byte1_reg;
        byte2_next = byte2_reg;
        byte3_next = byte3_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        if (cmd.load) begin
            case (count_reg[1:0])
                2'd0:    byte0_next = s_data.in_byte;
                2'd1:    byte1_next = s_data.in_byte;
                2'd2:    byte2_next = s_data.in_byte;
                default: byte3_next = s_data.in_byte;
            endcase
            count_next = count_reg + 3'd1;
        end
        if (cmd.decide) idx_next = 2'd0;
        if (push) begin
            idx_next = idx_reg + 2'd1;
            if (at_final) begin
                // drop the consumed bytes from the head of the queue
                case (take_reg)
                    3'd1: begin
                        byte0_next = byte1_reg;
                        byte1_next = byte2_reg;
                        byte2_next = byte3_reg;
                    end
                    3'd2: begin
                        byte0_next = byte2_reg;
                        byte1_next = byte3_reg;
                    end
                    3'd3:    byte0_next = byte3_reg;
                    default: byte0_next = byte0_reg;
                endcase
                count_next = count_reg - take_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        byte0_reg <= byte0_next;
        byte1_reg <= byte1_next;
        byte2_reg <= byte2_next;
        byte3_reg <= byte3_next;
        idx_reg <= idx_next;
        if (cmd.load) end_reg <= s_data.end_of_text;
        if (cmd.decide) more_reg <= dec_more;
        if (push) begin
            out_reg.out_char <= emit_char;
            out_reg.last_of_run <= at_final && !more_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 3'd0;
            out_valid_reg <= 1'b0;
            esc_reg <= 1'b0;
            take_reg <= 3'd1;
        end else begin
            count_reg <= count_next;
            if (push) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
            if (cmd.decide) begin
                esc_reg <= dec_esc;
                take_reg <= dec_take;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= u8ve_pkg::QUEUE_DEPTH)
        else $error("byte queue over capacity");

    a_load_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> count_reg != 3'd0)
        else $error("queue empty after a byte was loaded");

    a_take_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        take_reg != 3'd0 && take_reg <= u8ve_pkg::QUEUE_DEPTH)
        else $error("consume length out of range");

    a_push_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> $stable(out_reg))
        else $error("output register overwritten while stalled");

endmodule

@@ rtl/utf8_validate_escape.sv @@
// top level of the utf-8 validating escaper
//
//  channel   dir  handshake          payload
//  s_        in   s_valid/s_ready    u8ve_pkg::in_t  (in_byte, end_of_text)
//  m_        out  m_valid/m_ready    u8ve_pkg::out_t (out_char, last_of_run)
//
// an input byte is accepted only while the sequencer is idle, not while the
// queue head is judged or emitted; a printable byte yields one character, an
// escape four and a complete sequence its own bytes; the sequencer emits one
// character per cycle through a single output register while m_ready allows.
// reset (aresetn low, synchronous) empties the byte queue and the output
// register. a stall on m_ready freezes emission and holds s_ready low until
// the pending bytes are worked off.
module utf8_validate_escape (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  u8ve_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output u8ve_pkg::out_t m_data
);

    u8ve_pkg::cmd_t    cmd;
    u8ve_pkg::status_t status;

    u8ve_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    u8ve_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ dv/utf8_validate_escape_test.sv @@
// testbench for utf8_validate_escape: directed and random text checked against a byte-level predictor
`timescale 1ns / 1ps

module utf8_validate_escape_test;

    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES  = 300;

    // edge values, stray bytes and sequences broken as overlong, surrogate, out of range or by a non-continuation
    localparam logic [7:0] DIRECTED_TEXT [0:24] = '{
        8'h00, 8'h7F, 8'h7E, 8'h80, 8'hC1, 8'hF5, 8'hFF,
        8'hC2, 8'h80,
        8'hE0, 8'h9F, 8'hBF,
        8'hED, 8'hA0, 8'h80,
        8'hF4, 8'h8F, 8'hBF, 8'hBF,
        8'hF4, 8'h90, 8'h41,
        8'hE2, 8'h41, 8'h20
    };
    localparam int unsigned DIRECTED_EOT_A = 21;
    localparam int unsigned DIRECTED_EOT_B = 24;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    u8ve_pkg::in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    u8ve_pkg::out_t m_data;

    // predictor state: bytes held back while a sequence is still open
    logic [2:0][7:0] pending_bytes;
    int unsigned     pending_count = 0;
    u8ve_pkg::out_t  expected_chars [$];
    u8ve_pkg::out_t  want;

    int unsigned fail_count      = 0;
    int unsigned stall_cycles    = 0;
    int unsigned send_idle_pct   = 0;
    int unsigned recv_idle_pct   = 0;
    int unsigned hold_off_cycles = 0;

    utf8_validate_escape dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int unsigned utf8_len(input logic [7:0] lead);
        if (lead >= 8'hF5) return 0;
        if (lead >= 8'hF0) return 4;
        if (lead >= 8'hE0) return 3;
        if (lead >= 8'hC2) return 2;
        return 0;
    endfunction

    function automatic bit utf8_wellformed(input logic [3:0][7:0] text, input int unsigned at,
                                           input int unsigned len);
        int unsigned cp;
        int unsigned lowest;
        int unsigned k;
        case (len)
            2: begin
                cp = 32'(text[at] & 8'h1F);
                lowest = 'h80;
            end
            3: begin
                cp = 32'(text[at] & 8'h0F);
                lowest = 'h800;
            end
            default: begin
                cp = 32'(text[at] & 8'h07);
                lowest = 'h10000;
            end
        endcase
        for (k = 1; k < len; k++) begin
            if (text[at + k][7:6] != 2'b10) return 1'b0;
            cp = (cp << 6) | 32'(text[at + k][5:0]);
        end
        if (cp < lowest || cp > 'h10FFFF) return 1'b0;
        // surrogate halves are not scalar values
        if (cp >= 'hD800 && cp <= 'hDFFF) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] nibble);
        return (nibble < 4'd10) ? 8'h30 + {4'd0, nibble} : 8'h37 + {4'd0, nibble};
    endfunction

    function automatic void expect_char(input logic [7:0] c);
        u8ve_pkg::out_t entry;
        entry.out_char    = c;
        entry.last_of_run = 1'b0;
        expected_chars.insert(expected_chars.size(), entry);
    endfunction

    function automatic void expect_escape(input logic [7:0] b);
        expect_char(u8ve_pkg::CHAR_BACKSLASH);
        expect_char(u8ve_pkg::CHAR_X);
        expect_char(hex_ascii(b[7:4]));
        expect_char(hex_ascii(b[3:0]));
    endfunction

    function automatic void predict_escaped_text(input u8ve_pkg::in_t item);
        logic [3:0][7:0] text;
        int unsigned     total;
        int unsigned     pos;
        int unsigned     need;
        int unsigned     k;
        int unsigned     first;
        bit              waiting;
        first   = expected_chars.size();
        text    = '0;
        for (k = 0; k < pending_count; k++) text[k] = pending_bytes[k];
        text[pending_count] = item.in_byte;
        total   = pending_count + 1;
        pos     = 0;
        waiting = 1'b0;
        while (pos < total && !waiting) begin
            need = utf8_len(text[pos]);
            if (text[pos] < 8'h80) begin
                if (text[pos] >= u8ve_pkg::ASCII_SPACE && text[pos] != u8ve_pkg::ASCII_DEL)
                    expect_char(text[pos]);
                else expect_escape(text[pos]);
                pos++;
            end else if (need == 0) begin
                expect_escape(text[pos]);
                pos++;
            end else if (pos + need > total) begin
                // open sequence is held unless the text ends here
                if (item.end_of_text) begin
                    expect_escape(text[pos]);
                    pos++;
                end else begin
                    waiting = 1'b1;
                end
            end else if (utf8_wellformed(text, pos, need)) begin
                for (k = 0; k < need; k++) expect_char(text[pos + k]);
                pos += need;
            end else begin
                expect_escape(text[pos]);
                pos++;
            end
        end
        pending_count = total - pos;
        for (k = 0; k < pending_count; k++) pending_bytes[k] = text[pos + k];
        if (expected_chars.size() > first) expected_chars[$].last_of_run = 1'b1;
    endfunction

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            m_ready <= 1'b0;
            hold_off_cycles = hold_off_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected output transaction: out_char %h last_of_run %b",
                       m_data.out_char, m_data.last_of_run);
                fail_count++;
            end else begin
                want = expected_chars.pop_front();
                if (m_data.out_char !== want.out_char) begin
                    $error("out_char expected %h actual %h", want.out_char, m_data.out_char);
                    fail_count++;
                end
                if (m_data.last_of_run !== want.last_of_run) begin
                    $error("last_of_run expected %b actual %b",
                           want.last_of_run, m_data.last_of_run);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= '{in_byte: b, end_of_text: eot};
        do @(posedge aclk); while (!s_ready);
        predict_escaped_text('{in_byte: b, end_of_text: eot});
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // mostly well-formed sequences with random content, plus cut, damaged and noise bytes
    task automatic send_random_text(input int unsigned n_bytes);
        logic [3:0][7:0] seq;
        logic [20:0]     cp;
        int unsigned     len;
        int unsigned     keep;
        int unsigned     kind;
        int unsigned     k;
        int unsigned     sent;
        sent = 0;
        while (sent < n_bytes) begin
            kind = $urandom_range(99);
            len  = $urandom_range(4, 1);
            seq  = '0;
            case (len)
                1: seq[0] = 8'($urandom_range(8'h7E, 8'h20));
                2: begin
                    cp = 21'($urandom_range('h7FF, 'h80));
                    seq[0] = {3'b110, cp[10:6]};
                    seq[1] = {2'b10, cp[5:0]};
                end
                3: begin
                    cp = 21'($urandom_range('hFFFF, 'h800));
                    if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp - 21'h800;
                    seq[0] = {4'b1110, cp[15:12]};
                    seq[1] = {2'b10, cp[11:6]};
                    seq[2] = {2'b10, cp[5:0]};
                end
                default: begin
                    cp = 21'($urandom_range('h10FFFF, 'h10000));
                    seq[0] = {5'b11110, cp[20:18]};
                    seq[1] = {2'b10, cp[17:12]};
                    seq[2] = {2'b10, cp[11:6]};
                    seq[3] = {2'b10, cp[5:0]};
                end
            endcase
            keep = len;
            if (kind >= 60 && kind < 72 && len > 1) begin
                keep = $urandom_range(len - 1, 1);
            end else if (kind >= 72 && kind < 80 && len > 1) begin
                seq[$urandom_range(len - 1, 1)] = 8'($urandom_range(255));
            end else if (kind >= 80 && kind < 88) begin
                // edge leads; for E0, ED, F0 and F4 the second byte decides overlong, surrogate or out of range
                case ($urandom_range(6))
                    0: seq[0] = 8'hE0;
                    1: seq[0] = 8'hED;
                    2: seq[0] = 8'hF0;
                    3: seq[0] = 8'hF4;
                    4: seq[0] = 8'hC2;
                    5: seq[0] = 8'hDF;
                    default: seq[0] = 8'hEF;
                endcase
                len  = utf8_len(seq[0]);
                keep = len;
                for (k = 1; k < len; k++) seq[k] = 8'($urandom_range(8'hBF, 8'h80));
            end else if (kind >= 88) begin
                keep   = 1;
                seq[0] = 8'($urandom_range(255));
            end
            for (k = 0; k < keep && sent < n_bytes; k++) begin
                send_byte(seq[k], (sent == n_bytes - 1) || ($urandom_range(19) == 0));
                sent++;
            end
        end
    endtask

    task automatic test_directed_cases();
        int unsigned k;
        for (k = 0; k < 25; k++)
            send_byte(DIRECTED_TEXT[k], (k == DIRECTED_EOT_A) || (k == DIRECTED_EOT_B));
        wait_for_drain();
    endtask

    task automatic test_random_text(input int unsigned n_bytes);
        send_random_text(n_bytes);
        wait_for_drain();
    endtask

    // receiver holds off while the sender keeps offering, so the block backs up
    task automatic test_output_hold_off();
        @(negedge aclk);
        hold_off_cycles = HOLD_CYCLES;
        @(posedge aclk);
        send_random_text(24);
        wait_for_drain();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 33;
        recv_idle_pct = 54;
        test_directed_cases();
        test_random_text(25);

        send_idle_pct = 54;
        recv_idle_pct = 33;
        test_random_text(25);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_text(25);

        test_output_hold_off();

        if (fail_count == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule
